// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL (used by lsq_queue). Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LSQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define LSQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
        else $error("assertion failed");
`else
`define LSQ_ASSERT(lbl, clk, rstn, prop)
`define LSQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/lsq_pkg.sv =====
`default_nettype none
package lsq_pkg;
    localparam int ROW_WIDTH = 256;
    localparam int COL_W     = $clog2(ROW_WIDTH);
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef logic [COL_W-1:0] col_t;

    typedef enum logic [1:0] {
        SLOT0 = 2'd0,
        SLOT1 = 2'd1,
        SLOT2 = 2'd2
    } slot_t;

    // One classified sample on its way from the front to the back.
    typedef struct packed {
        logic signed [31:0] sample;
        col_t               col;
        slot_t              slot;
        logic               emit;
    } item_t;
endpackage
`default_nettype wire

// ===== design/lsq_front.sv =====
`default_nettype none
module lsq_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sample,
    input  logic               s_frame_start,
    input  logic               q_full,
    output logic               push,
    output lsq_pkg::item_t     push_item
);
    import lsq_pkg::*;

    localparam logic [1:0] ROWS_FULL = 2'd3;

    col_t       col_reg, col_next, col_cur;
    logic [1:0] rows_reg, rows_next, rows_cur;
    slot_t      slot_reg, slot_next, slot_cur, slot_inc;
    logic       row_end;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        // A frame start restarts the grid before this beat is placed.
        col_cur  = s_frame_start ? '0 : col_reg;
        rows_cur = s_frame_start ? '0 : rows_reg;
        slot_cur = s_frame_start ? SLOT0 : slot_reg;
        row_end  = (col_cur == COL_W'(ROW_WIDTH - 1));

        unique case (slot_cur)
            SLOT0:   slot_inc = SLOT1;
            SLOT1:   slot_inc = SLOT2;
            SLOT2:   slot_inc = SLOT0;
            default: slot_inc = SLOT0;
        endcase

        push_item.sample = s_sample;
        push_item.col    = col_cur;
        push_item.slot   = slot_cur;
        push_item.emit   = (rows_cur == ROWS_FULL) && (col_cur >= COL_W'(4));

        col_next  = col_reg;
        rows_next = rows_reg;
        slot_next = slot_reg;
        if (push) begin
            if (row_end) begin
                col_next  = '0;
                slot_next = slot_inc;
                rows_next = (rows_cur == ROWS_FULL) ? ROWS_FULL : rows_cur + 2'd1;
            end else begin
                col_next  = col_cur + COL_W'(1);
                slot_next = slot_cur;
                rows_next = rows_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            rows_reg <= '0;
            slot_reg <= SLOT0;
        end else begin
            col_reg  <= col_next;
            rows_reg <= rows_next;
            slot_reg <= slot_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/lsq_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module lsq_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lsq_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output lsq_pkg::item_t pop_item,
    output logic           empty
);
    import lsq_pkg::*;

    item_t                q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = q_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `LSQ_ASSERT(a_no_overflow, aclk, aresetn, !(push && full))
    `LSQ_ASSERT(a_no_underflow, aclk, aresetn, !(pop && empty))
    `LSQ_ASSERT_NEXT(a_count_fill, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)
endmodule
`default_nettype wire

// ===== design/lsq_back.sv =====
`default_nettype none
module lsq_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    output logic               pop,
    input  lsq_pkg::item_t     pop_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_lap_mid,
    output logic signed [31:0] m_lap_west,
    output logic signed [31:0] m_lap_east,
    output logic signed [31:0] m_lap_south,
    output logic [7:0]         m_centre_column
);
    import lsq_pkg::*;

    localparam int LAP_MID   = 0;
    localparam int LAP_WEST  = 1;
    localparam int LAP_EAST  = 2;
    localparam int LAP_SOUTH = 3;
    localparam int NUM_SLOTS = 3;

    typedef struct packed {
        logic signed [34:0] centre;
        logic signed [32:0] sides;
    } lap_part_t;

    function automatic logic signed [34:0] centre_part(
        input logic signed [31:0] c,
        input logic signed [31:0] u,
        input logic signed [31:0] d
    );
        return (35'(c) <<< 2) - 35'(u) - 35'(d);
    endfunction

    function automatic logic signed [32:0] side_part(
        input logic signed [31:0] l,
        input logic signed [31:0] r
    );
        return 33'(l) + 33'(r);
    endfunction

    function automatic logic signed [31:0] finish_lap(input lap_part_t p);
        logic signed [35:0] full_sum;
        full_sum = 36'(p.centre) - 36'(p.sides);
        // In range exactly when the top five bits agree.
        if ((full_sum[35:31] == 5'b00000) || (full_sum[35:31] == 5'b11111)) begin
            return full_sum[31:0];
        end else if (full_sum[35]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

    logic en;

    // Read data of the three row slots, all addressed by the column.
    logic signed [31:0] rd_reg [NUM_SLOTS];

    logic               v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic signed [31:0] sample1_reg;
    slot_t              slot1_reg;
    logic               emit1_reg, emit2_reg, emit3_reg;
    col_t               m1_reg, m2_reg, m3_reg;

    // Windows over the last columns of four rows; index 0 is the newest column.
    logic signed [31:0] w0_reg [3];
    logic signed [31:0] w1_reg [4];
    logic signed [31:0] w2_reg [5];
    logic signed [31:0] w3_reg [4];

    logic signed [31:0] rd_old, rd_r2, rd_r1;
    lap_part_t          part_next [4];
    lap_part_t          part_reg  [4];
    logic signed [31:0] lap_reg   [4];
    col_t               centre_reg;

    assign en  = !m_valid_reg || m_ready;
    assign pop = !q_empty && en;

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
        logic signed [31:0] line_mem [ROW_WIDTH];

        // Read-first: the oldest row's value leaves before the new sample lands.
        always_ff @(posedge aclk) begin
            if (pop) begin
                if (pop_item.slot == slot_t'(k)) begin
                    line_mem[pop_item.col] <= pop_item.sample;
                end
                rd_reg[k] <= line_mem[pop_item.col];
            end
        end
    end

    always_comb begin
        unique case (slot1_reg)
            SLOT0: begin
                rd_old = rd_reg[0];
                rd_r2  = rd_reg[1];
                rd_r1  = rd_reg[2];
            end
            SLOT1: begin
                rd_old = rd_reg[1];
                rd_r2  = rd_reg[2];
                rd_r1  = rd_reg[0];
            end
            SLOT2: begin
                rd_old = rd_reg[2];
                rd_r2  = rd_reg[0];
                rd_r1  = rd_reg[1];
            end
            default: begin
                rd_old = rd_reg[0];
                rd_r2  = rd_reg[1];
                rd_r1  = rd_reg[2];
            end
        endcase
    end

    always_comb begin
        part_next[LAP_MID].centre   = centre_part(w2_reg[2], w3_reg[2], w1_reg[2]);
        part_next[LAP_MID].sides    = side_part(w2_reg[3], w2_reg[1]);
        part_next[LAP_WEST].centre  = centre_part(w2_reg[3], w3_reg[3], w1_reg[3]);
        part_next[LAP_WEST].sides   = side_part(w2_reg[4], w2_reg[2]);
        part_next[LAP_EAST].centre  = centre_part(w2_reg[1], w3_reg[1], w1_reg[1]);
        part_next[LAP_EAST].sides   = side_part(w2_reg[2], w2_reg[0]);
        part_next[LAP_SOUTH].centre = centre_part(w1_reg[2], w2_reg[2], w0_reg[2]);
        part_next[LAP_SOUTH].sides  = side_part(w1_reg[3], w1_reg[1]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (pop) begin
                sample1_reg <= pop_item.sample;
                slot1_reg   <= pop_item.slot;
                emit1_reg   <= pop_item.emit;
                m1_reg      <= pop_item.col - COL_W'(2);
            end
            if (v1_reg) begin
                w0_reg[0] <= sample1_reg;
                w1_reg[0] <= rd_r1;
                w2_reg[0] <= rd_r2;
                w3_reg[0] <= rd_old;
                for (int i = 1; i < 3; i++) begin
                    w0_reg[i] <= w0_reg[i-1];
                end
                for (int i = 1; i < 4; i++) begin
                    w1_reg[i] <= w1_reg[i-1];
                    w3_reg[i] <= w3_reg[i-1];
                end
                for (int i = 1; i < 5; i++) begin
                    w2_reg[i] <= w2_reg[i-1];
                end
                emit2_reg <= emit1_reg;
                m2_reg    <= m1_reg;
            end
            if (v2_reg) begin
                for (int i = 0; i < 4; i++) begin
                    part_reg[i] <= part_next[i];
                end
                emit3_reg <= emit2_reg;
                m3_reg    <= m2_reg;
            end
            if (v3_reg && emit3_reg) begin
                for (int i = 0; i < 4; i++) begin
                    lap_reg[i] <= finish_lap(part_reg[i]);
                end
                centre_reg <= m3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= pop;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg && emit3_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_lap_mid       = lap_reg[LAP_MID];
    assign m_lap_west      = lap_reg[LAP_WEST];
    assign m_lap_east      = lap_reg[LAP_EAST];
    assign m_lap_south     = lap_reg[LAP_SOUTH];
    assign m_centre_column = 8'(centre_reg);
endmodule
`default_nettype wire

// ===== design/laplacian_stencil_quad_top.sv =====
// Path: an accepted sample is written into the queue and then passes the line store read,
// window shift, partial sums and saturation register before its result beat is valid.
// Throughput: one sample per cycle while s_ready is high. While a result waits on m_ready,
// the back pipeline stalls as a whole and the four-entry queue takes up to four more beats
// before s_ready falls. Reset (aresetn low, synchronous) clears the counts, the queue and
// all valid bits; the line store is not cleared, and only written entries feed a result.
`default_nettype none
module laplacian_stencil_quad_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sample,
    input  logic               s_frame_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_lap_mid,
    output logic signed [31:0] m_lap_west,
    output logic signed [31:0] m_lap_east,
    output logic signed [31:0] m_lap_south,
    output logic [7:0]         m_centre_column
);
    import lsq_pkg::*;

    logic  q_full, q_empty, push, pop;
    item_t push_item, pop_item;

    lsq_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_frame_start (s_frame_start),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    lsq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    lsq_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .pop             (pop),
        .pop_item        (pop_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lap_mid       (m_lap_mid),
        .m_lap_west      (m_lap_west),
        .m_lap_east      (m_lap_east),
        .m_lap_south     (m_lap_south),
        .m_centre_column (m_centre_column)
    );
endmodule
`default_nettype wire

// ===== verif/laplacian_stencil_quad_top_tb.sv =====
module laplacian_stencil_quad_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsq_pkg::ROW_WIDTH;

    localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_ZERO = 32'sd0;
    localparam int RANDOM_SAMPLES = 140;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ONE_AT = 920;
    localparam int PHASE_TWO_AT = 1069;
    localparam int SEND_IDLE [3] = '{14, 84, 0};
    localparam int RECV_IDLE [3] = '{84, 14, 0};

    typedef struct packed {
        logic signed [31:0] mid;
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic signed [31:0] down;
        logic [7:0]         col;
    } lap_beat_t;

    typedef enum logic {
        FILL_FLAT,
        FILL_NOISE
    } row_fill_e;

    // One run of samples in the directed walk. Where typed is set, every beat that
    // the run produces carries the four Laplacians given here.
    typedef struct packed {
        row_fill_e          fill;
        logic signed [31:0] level;
        logic [15:0]        len;
        logic               restart;
        logic               typed;
        logic signed [31:0] want_mid;
        logic signed [31:0] want_left;
        logic signed [31:0] want_right;
        logic signed [31:0] want_down;
    } row_plan_t;

    localparam int PLAN_ROWS = 16;
    localparam row_plan_t ROW_PLAN [PLAN_ROWS] = '{
        // A short run straight after reset, then a new grid that is itself cut short.
        '{FILL_NOISE, S_ZERO, 16'd20,  1'b0, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{FILL_NOISE, S_ZERO, 16'd25,  1'b1, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        // A clean grid in three column bands. Left band: a lone maximum row between
        // minimum rows. Middle band: the mirror image. Right band: flat maximum.
        '{FILL_FLAT,  S_MIN,  16'd85,  1'b1, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{FILL_FLAT,  S_MAX,  16'd85,  1'b0, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{FILL_FLAT,  S_MAX,  16'd86,  1'b0, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{FILL_FLAT,  S_MAX,  16'd85,  1'b0, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{FILL_FLAT,  S_MIN,  16'd85,  1'b0, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{FILL_FLAT,  S_MAX,  16'd86,  1'b0, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{FILL_FLAT,  S_MIN,  16'd85,  1'b0, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{FILL_FLAT,  S_MAX,  16'd85,  1'b0, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{FILL_FLAT,  S_MAX,  16'd86,  1'b0, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        // Newest row: windows that straddle two bands are left to the predictor.
        '{FILL_FLAT,  S_MIN,  16'd85,  1'b0, 1'b1, S_MAX,  S_MAX,  S_MAX,  S_MIN},
        '{FILL_FLAT,  S_MAX,  16'd4,   1'b0, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{FILL_FLAT,  S_MAX,  16'd81,  1'b0, 1'b1, S_MIN,  S_MIN,  S_MIN,  S_MAX},
        '{FILL_FLAT,  S_MAX,  16'd4,   1'b0, 1'b0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{FILL_FLAT,  S_MAX,  16'd82,  1'b0, 1'b1, S_ZERO, S_ZERO, S_ZERO, S_ZERO}
    };

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_sample;
    logic               s_frame_start;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_lap_mid;
    logic signed [31:0] m_lap_west;
    logic signed [31:0] m_lap_east;
    logic signed [31:0] m_lap_south;
    logic [7:0]         m_centre_column;

    // Predictor state: three row slots, the history of overwritten r-3 values,
    // and the grid position.
    bit signed [31:0] line_mem [3*ROW_WIDTH];
    logic signed [31:0] up_hist [4];
    int next_col;
    int full_rows;
    int oldest_slot;

    lap_beat_t expected_laps [$];
    int error_count;
    int samples_sent;
    int beats_predicted;
    int beats_checked;
    int idle_phase;

    laplacian_stencil_quad_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lap_mid       (m_lap_mid),
        .m_lap_west      (m_lap_west),
        .m_lap_east      (m_lap_east),
        .m_lap_south     (m_lap_south),
        .m_centre_column (m_centre_column)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic signed [31:0] stored(input int slot, input int col);
        return line_mem[slot*ROW_WIDTH + col];
    endfunction

    function automatic logic signed [31:0] lap_sat(input logic signed [31:0] c,
                                                   input logic signed [31:0] u,
                                                   input logic signed [31:0] d,
                                                   input logic signed [31:0] l,
                                                   input logic signed [31:0] r);
        longint v;
        v = 4 * longint'(c) - longint'(u) - longint'(d) - longint'(l) - longint'(r);
        if (v > longint'(S_MAX)) begin
            v = longint'(S_MAX);
        end
        if (v < longint'(S_MIN)) begin
            v = longint'(S_MIN);
        end
        return v[31:0];
    endfunction

    function automatic void stencil_predict(input logic signed [31:0] smp, input bit fs,
                                            output bit produced, output lap_beat_t beat);
        int col;
        int m;
        int s3;
        int s2;
        int s1;
        if (fs) begin
            next_col = 0;
            full_rows = 0;
            oldest_slot = 0;
        end
        col = next_col;
        s3 = oldest_slot;
        s2 = (s3 + 1) % 3;
        s1 = (s3 + 2) % 3;
        // The row r-3 value leaves the store here, so keep it for the upper taps.
        up_hist[3] = up_hist[2];
        up_hist[2] = up_hist[1];
        up_hist[1] = up_hist[0];
        up_hist[0] = stored(s3, col);
        line_mem[s3*ROW_WIDTH + col] = smp;
        produced = 1'b0;
        beat = '0;
        if (full_rows >= 3 && col >= 4) begin
            m = col - 2;
            beat.mid = lap_sat(stored(s2, m), up_hist[2], stored(s1, m),
                               stored(s2, m - 1), stored(s2, m + 1));
            beat.left = lap_sat(stored(s2, m - 1), up_hist[3], stored(s1, m - 1),
                                stored(s2, m - 2), stored(s2, m));
            beat.right = lap_sat(stored(s2, m + 1), up_hist[1], stored(s1, m + 1),
                                 stored(s2, m), stored(s2, m + 2));
            beat.down = lap_sat(stored(s1, m), stored(s2, m), stored(s3, m),
                                stored(s1, m - 1), stored(s1, m + 1));
            beat.col = 8'(m);
            produced = 1'b1;
        end
        next_col = next_col + 1;
        if (next_col == ROW_WIDTH) begin
            next_col = 0;
            oldest_slot = s2;
            if (full_rows < 3) begin
                full_rows = full_rows + 1;
            end
        end
    endfunction

    function automatic logic signed [31:0] noise_sample();
        case ($urandom_range(7))
            0: return S_MIN;
            1: return S_MAX;
            2: return S_ZERO;
            3: return -32'sd1;
            4: return $signed($urandom_range(200)) - 32'sd100;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic feed_sample(input logic signed [31:0] smp, input bit fs, input bit typed,
                               input lap_beat_t typed_laps);
        bit produced;
        lap_beat_t beat;
        idle_phase = (samples_sent < PHASE_ONE_AT) ? 0 :
                     ((samples_sent < PHASE_TWO_AT) ? 1 : 2);
        while ($urandom_range(99) < SEND_IDLE[idle_phase]) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_sample = smp;
        s_frame_start = fs;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        stencil_predict(smp, fs, produced, beat);
        if (produced) begin
            if (typed) begin
                beat.mid = typed_laps.mid;
                beat.left = typed_laps.left;
                beat.right = typed_laps.right;
                beat.down = typed_laps.down;
            end
            expected_laps.push_back(beat);
            beats_predicted++;
        end
        samples_sent++;
        @(negedge aclk);
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= RECV_IDLE[idle_phase]);
        end
    end

    always @(posedge aclk) begin
        lap_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_laps.size() == 0) begin
                $error("result beat with no expectation, centre column %0d", m_centre_column);
                error_count++;
            end else begin
                want = expected_laps.pop_front();
                check_field("lap_mid", want.mid, m_lap_mid);
                check_field("lap_west", want.left, m_lap_west);
                check_field("lap_east", want.right, m_lap_east);
                check_field("lap_south", want.down, m_lap_south);
                check_field("centre_column", {24'd0, want.col}, {24'd0, m_centre_column});
                beats_checked++;
            end
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_laps.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        int r;
        int k;
        int rand_sent;
        logic signed [31:0] smp;
        lap_beat_t typed_laps;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_sample = '0;
        s_frame_start = 1'b0;
        error_count = 0;
        samples_sent = 0;
        beats_predicted = 0;
        beats_checked = 0;
        idle_phase = 0;
        next_col = 0;
        full_rows = 0;
        oldest_slot = 0;
        for (k = 0; k < 4; k++) begin
            up_hist[k] = '0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (r = 0; r < PLAN_ROWS; r++) begin
            typed_laps = '0;
            typed_laps.mid = ROW_PLAN[r].want_mid;
            typed_laps.left = ROW_PLAN[r].want_left;
            typed_laps.right = ROW_PLAN[r].want_right;
            typed_laps.down = ROW_PLAN[r].want_down;
            for (k = 0; k < int'(ROW_PLAN[r].len); k++) begin
                smp = (ROW_PLAN[r].fill == FILL_FLAT) ? ROW_PLAN[r].level : noise_sample();
                feed_sample(smp, ROW_PLAN[r].restart && (k == 0), ROW_PLAN[r].typed,
                            typed_laps);
            end
        end

        // Hold the input off until the pipeline has drained completely.
        s_valid = 1'b0;
        while (expected_laps.size() != 0) begin
            @(negedge aclk);
        end

        // Continue the warm grid with random samples.
        rand_sent = 0;
        while (rand_sent < RANDOM_SAMPLES) begin
            feed_sample(noise_sample(), 1'b0, 1'b0, '0);
            rand_sent++;
        end
        s_valid = 1'b0;

        while (expected_laps.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Streamed %0d samples over restarted, banded saturating and random grids;",
                 samples_sent);
        $display("checked %0d of %0d predicted result beats under mixed back-pressure.",
                 beats_checked, beats_predicted);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/lsq_pkg.sv
design/lsq_front.sv
design/lsq_queue.sv
design/lsq_back.sv
design/laplacian_stencil_quad_top.sv
verif/laplacian_stencil_quad_top_tb.sv
